// ===== rtl/wodr_pkg.sv =====
// Shared widths, constants and the CORDIC angle table for the odometry block.
`timescale 1ns / 1ps
`default_nettype none

package wodr_pkg;

  // Field widths
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 16;
  localparam int RATE_W   = 21;
  localparam int POS_W    = 32;
  localparam int ANG_W    = 29;
  localparam int TRIG_W   = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10000;

  // Parameter defaults
  localparam int CORDIC_ITERS_DEF = 16;
  localparam int OFFSET_W_DEF     = 48;

  // Angle table depth and index width
  localparam int ATAN_DEPTH = 32;
  localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

  // Heading sum width and turn constants in microdegrees
  localparam int HSUM_W = ANG_W + 1;
  localparam logic signed [HSUM_W-1:0] QUARTER_TURN = HSUM_W'(90000000);
  localparam logic signed [HSUM_W-1:0] HALF_TURN    = HSUM_W'(180000000);
  localparam logic signed [HSUM_W-1:0] FULL_TURN    = HSUM_W'(360000000);

  // |turn_rate * period| < 2^36; its quotient by 1000 stays below 2^27
  localparam int RATE_PROD_W = 37;
  localparam int HQ_W        = 27;

  // atan(2^-i) in microdegrees, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_udeg(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(45000000);
      5'd1:    v = ANG_W'(26565051);
      5'd2:    v = ANG_W'(14036243);
      5'd3:    v = ANG_W'(7125016);
      5'd4:    v = ANG_W'(3576334);
      5'd5:    v = ANG_W'(1789911);
      5'd6:    v = ANG_W'(895174);
      5'd7:    v = ANG_W'(447614);
      5'd8:    v = ANG_W'(223811);
      5'd9:    v = ANG_W'(111906);
      5'd10:   v = ANG_W'(55953);
      5'd11:   v = ANG_W'(27976);
      5'd12:   v = ANG_W'(13988);
      5'd13:   v = ANG_W'(6994);
      5'd14:   v = ANG_W'(3497);
      5'd15:   v = ANG_W'(1749);
      5'd16:   v = ANG_W'(874);
      5'd17:   v = ANG_W'(437);
      5'd18:   v = ANG_W'(219);
      5'd19:   v = ANG_W'(109);
      5'd20:   v = ANG_W'(55);
      5'd21:   v = ANG_W'(27);
      5'd22:   v = ANG_W'(14);
      5'd23:   v = ANG_W'(7);
      5'd24:   v = ANG_W'(3);
      5'd25:   v = ANG_W'(2);
      5'd26:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wodr_if.sv =====
// Valid/ready channel interfaces for the odometry input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface wodr_in_if;
  import wodr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_mm_s;
  logic signed [RATE_W-1:0]  turn_rate_mdeg_s;
  logic signed [POS_W-1:0]   fix_x_um;
  logic signed [POS_W-1:0]   fix_y_um;

  modport source (output valid, speed_mm_s, turn_rate_mdeg_s, fix_x_um, fix_y_um,
                  input ready);
  modport sink (input valid, speed_mm_s, turn_rate_mdeg_s, fix_x_um, fix_y_um,
                output ready);
endinterface

interface wodr_out_if;
  import wodr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x_um;
  logic signed [POS_W-1:0] pos_y_um;
  logic signed [ANG_W-1:0] heading_out_udeg;

  modport source (output valid, pos_x_um, pos_y_um, heading_out_udeg, input ready);
  modport sink (input valid, pos_x_um, pos_y_um, heading_out_udeg, output ready);
endinterface

`default_nettype wire

// ===== rtl/wheel_odometry_dead_reckoning.sv =====
// Top level of the dead-reckoning odometry block: sequencer, shared multiplier, state.
//
// Usage:
//   in_ch  (valid/ready): one odometry tick carrying speed, turn rate and a position fix.
//   out_ch (valid/ready): one result per tick, fix plus accumulated offset and heading.
//   cfg_wr_en/cfg_wr_data: write the tick period in microseconds; write only while idle.
// Each tick runs through one sequencer that reuses a single 32x17 multiplier, a
// constant divide-by-1000 unit (one 16-bit quotient digit per cycle by reciprocal
// multiplication) and an iterative CORDIC.
// The time from transfer in to result valid is set by the three passes through the
// divider (heading step, x position, y position) and the CORDIC loop. in_ch.ready is
// high only while the sequencer is idle, so a new tick is not taken until the
// sequencer has passed the last tick's result on to the output register.
// A finished result sits in an output register; the next tick is taken while it waits.
// When the receiver stalls, the sequencer holds the next result in its last state
// until the output register is free.
// Reset clears heading and offsets to zero, sets the period to 10000 us and drops
// any pending result.
`timescale 1ns / 1ps
`default_nettype none

module wheel_odometry_dead_reckoning #(
  parameter int CORDIC_ITERATIONS = wodr_pkg::CORDIC_ITERS_DEF,
  parameter int OFFSET_WIDTH      = wodr_pkg::OFFSET_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [wodr_pkg::PERIOD_W-1:0]   cfg_wr_data,
  wodr_in_if.sink                         in_ch,
  wodr_out_if.source                      out_ch
);
  import wodr_pkg::*;

  // Widths that follow from the offset accumulator size
  localparam int DIV_W  = (OFFSET_WIDTH > RATE_PROD_W) ? OFFSET_WIDTH : RATE_PROD_W;
  localparam int MUL_AW = 32;
  localparam int MUL_BW = PERIOD_W + 1;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int D_W    = 33;
  localparam int SUM_W  = ((OFFSET_WIDTH > D_W) ? OFFSET_WIDTH : D_W) + 1;
  localparam int PW     = DIV_W + 3;

  localparam logic signed [SUM_W-1:0] OFF_HI =
    {{(SUM_W - OFFSET_WIDTH + 1){1'b0}}, {(OFFSET_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] OFF_LO = ~OFF_HI;
  localparam logic signed [PW-1:0] POS_HI = {{(PW - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [PW-1:0] POS_LO = ~POS_HI;

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_D   = 4'd1;
  localparam logic [3:0] S_MUL_R   = 4'd2;
  localparam logic [3:0] S_DIV_H   = 4'd3;
  localparam logic [3:0] S_WAIT_H  = 4'd4;
  localparam logic [3:0] S_CORD_GO = 4'd5;
  localparam logic [3:0] S_WAIT_C  = 4'd6;
  localparam logic [3:0] S_MUL_X   = 4'd7;
  localparam logic [3:0] S_ACC_X   = 4'd8;
  localparam logic [3:0] S_ACC_Y   = 4'd9;
  localparam logic [3:0] S_DIV_X   = 4'd10;
  localparam logic [3:0] S_WAIT_X  = 4'd11;
  localparam logic [3:0] S_WAIT_Y  = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0] state_r, state_nxt;

  // Configuration and state
  logic [PERIOD_W-1:0]           per_r;
  logic signed [ANG_W-1:0]       heading_r;
  logic signed [OFFSET_WIDTH-1:0] offx_r, offy_r;

  // Captured tick
  logic signed [SPEED_W-1:0] speed_r;
  logic signed [RATE_W-1:0]  rate_r;
  logic signed [POS_W-1:0]   fixx_r, fixy_r;

  // Working registers
  logic signed [MUL_AW-1:0] dist_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     sign_r;
  logic signed [POS_W-1:0]  posx_r, posy_r;

  // Output register
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_x_r, out_y_r;
  logic signed [ANG_W-1:0]  out_h_r;

  // Shared multiplier
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic                     mul_en;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_neg;

  // Divider hookup
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quot;
  logic                    div_rem_nz;
  logic [RATE_PROD_W-1:0]  rate_mag;
  logic [OFFSET_WIDTH-1:0] offx_mag, offy_mag;

  // CORDIC hookup
  logic                     cor_start;
  logic                     cor_done;
  logic signed [TRIG_W-1:0] cor_cos, cor_sin;

  // Heading step
  logic signed [HSUM_W-1:0] dh_mag, dh, h_sum, h_wrap;

  // Offset accumulate
  logic signed [D_W-1:0]          d_step;
  logic signed [OFFSET_WIDTH-1:0] off_sel;
  logic signed [SUM_W-1:0]        off_sum;
  logic signed [OFFSET_WIDTH-1:0] off_sat;

  // Position from quotient
  logic [DIV_W:0]           pq_mag;
  logic signed [DIV_W+1:0]  pq;
  logic signed [POS_W-1:0]  fix_sel;
  logic signed [PW-1:0]     p_sum;
  logic signed [POS_W-1:0]  p_sat;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_ch.valid & in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Multiplier operand select: distance, heading step, then the two trig products
  always_comb begin
    mul_en = 1'b1;
    case (state_r)
      S_MUL_D: begin
        mul_a = MUL_AW'(speed_r);
        mul_b = $signed({1'b0, per_r});
      end
      S_MUL_R: begin
        mul_a = MUL_AW'(rate_r);
        mul_b = $signed({1'b0, per_r});
      end
      S_MUL_X: begin
        mul_a = dist_r;
        mul_b = MUL_BW'(cor_cos);
      end
      S_ACC_X: begin
        mul_a = dist_r;
        mul_b = MUL_BW'(cor_sin);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = dist_r;
        mul_b  = MUL_BW'(cor_cos);
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_neg = -prod_r;

  // Magnitudes handed to the divider; signs are applied afterwards
  assign rate_mag = prod_r[PROD_W-1] ? prod_neg[RATE_PROD_W-1:0] : prod_r[RATE_PROD_W-1:0];
  assign offx_mag = offx_r[OFFSET_WIDTH-1] ? (~offx_r + OFFSET_WIDTH'(1)) : offx_r;
  assign offy_mag = offy_r[OFFSET_WIDTH-1] ? (~offy_r + OFFSET_WIDTH'(1)) : offy_r;

  always_comb begin
    case (state_r)
      S_DIV_H:  div_dividend = DIV_W'(rate_mag);
      S_DIV_X:  div_dividend = DIV_W'(offx_mag);
      S_WAIT_X: div_dividend = DIV_W'(offy_mag);
      default:  div_dividend = DIV_W'(offx_mag);
    endcase
  end

  assign div_start = (state_r == S_DIV_H) || (state_r == S_DIV_X) ||
                     ((state_r == S_WAIT_X) && div_done);
  assign cor_start = (state_r == S_CORD_GO);

  wodr_div1000 #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  wodr_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (heading_r),
    .done    (cor_done),
    .cos_q15 (cor_cos),
    .sin_q15 (cor_sin)
  );

  // Heading step truncates toward zero, then fold into [-180, 180) degrees
  always_comb begin
    dh_mag = $signed(HSUM_W'(div_quot[HQ_W-1:0]));
    dh     = sign_r ? -dh_mag : dh_mag;
    h_sum  = HSUM_W'(heading_r) + dh;
    if (h_sum >= HALF_TURN) begin
      h_wrap = h_sum - FULL_TURN;
    end else if (h_sum < -HALF_TURN) begin
      h_wrap = h_sum + FULL_TURN;
    end else begin
      h_wrap = h_sum;
    end
  end

  // Offset accumulate: floor shift of the trig product, saturating add
  always_comb begin
    d_step  = prod_r[D_W+14:15];
    off_sel = (state_r == S_ACC_X) ? offx_r : offy_r;
    off_sum = SUM_W'(off_sel) + SUM_W'(d_step);
    if (off_sum > OFF_HI) begin
      off_sat = OFF_HI[OFFSET_WIDTH-1:0];
    end else if (off_sum < OFF_LO) begin
      off_sat = OFF_LO[OFFSET_WIDTH-1:0];
    end else begin
      off_sat = off_sum[OFFSET_WIDTH-1:0];
    end
  end

  // Position: floor quotient of a negative offset rounds away from zero
  always_comb begin
    pq_mag  = {1'b0, div_quot} + {{DIV_W{1'b0}}, sign_r & div_rem_nz};
    pq      = sign_r ? -$signed({1'b0, pq_mag}) : $signed({1'b0, pq_mag});
    fix_sel = (state_r == S_WAIT_X) ? fixx_r : fixy_r;
    p_sum   = PW'(fix_sel) + PW'(pq);
    if (p_sum > POS_HI) begin
      p_sat = POS_HI[POS_W-1:0];
    end else if (p_sum < POS_LO) begin
      p_sat = POS_LO[POS_W-1:0];
    end else begin
      p_sat = p_sum[POS_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_xfer) state_nxt = S_MUL_D;
      S_MUL_D:   state_nxt = S_MUL_R;
      S_MUL_R:   state_nxt = S_DIV_H;
      S_DIV_H:   state_nxt = S_WAIT_H;
      S_WAIT_H:  if (div_done) state_nxt = S_CORD_GO;
      S_CORD_GO: state_nxt = S_WAIT_C;
      S_WAIT_C:  if (cor_done) state_nxt = S_MUL_X;
      S_MUL_X:   state_nxt = S_ACC_X;
      S_ACC_X:   state_nxt = S_ACC_Y;
      S_ACC_Y:   state_nxt = S_DIV_X;
      S_DIV_X:   state_nxt = S_WAIT_X;
      S_WAIT_X:  if (div_done) state_nxt = S_WAIT_Y;
      S_WAIT_Y:  if (div_done) state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      per_r       <= PERIOD_RST;
      heading_r   <= '0;
      offx_r      <= '0;
      offy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        per_r <= cfg_wr_data;
      end
      if ((state_r == S_WAIT_H) && div_done) begin
        heading_r <= h_wrap[ANG_W-1:0];
      end
      if (state_r == S_ACC_X) begin
        offx_r <= off_sat;
      end
      if (state_r == S_ACC_Y) begin
        offy_r <= off_sat;
      end
      // Drop the result once taken; load the next one when the register is free
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      speed_r <= in_ch.speed_mm_s;
      rate_r  <= in_ch.turn_rate_mdeg_s;
      fixx_r  <= in_ch.fix_x_um;
      fixy_r  <= in_ch.fix_y_um;
    end
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_MUL_R) begin
      dist_r <= prod_r[MUL_AW-1:0];
    end
    case (state_r)
      S_DIV_H:  sign_r <= prod_r[PROD_W-1];
      S_DIV_X:  sign_r <= offx_r[OFFSET_WIDTH-1];
      S_WAIT_X: if (div_done) sign_r <= offy_r[OFFSET_WIDTH-1];
      default:  sign_r <= sign_r;
    endcase
    if ((state_r == S_WAIT_X) && div_done) begin
      posx_r <= p_sat;
    end
    if ((state_r == S_WAIT_Y) && div_done) begin
      posy_r <= p_sat;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_x_r <= posx_r;
      out_y_r <= posy_r;
      out_h_r <= heading_r;
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pos_x_um         = out_x_r;
  assign out_ch.pos_y_um         = out_y_r;
  assign out_ch.heading_out_udeg = out_h_r;

endmodule

`default_nettype wire

// ===== rtl/wodr_div1000.sv =====
// Divider by the constant 1000, one 16-bit quotient digit per cycle by reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module wodr_div1000 #(
  parameter int DIV_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic             rem_nz
);
  localparam int DIGIT  = 16;
  localparam int STEPS  = (DIV_W + DIGIT - 1) / DIGIT;
  localparam int PAD    = STEPS * DIGIT;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int REM_W  = 10;
  localparam int PART_W = REM_W + DIGIT;
  // ceil(2^36 / 1000): exact quotient for every partial below 1000 * 2^16
  localparam int RCP_SH = 36;
  localparam int RCP_W  = 27;
  localparam int PRD_W  = PART_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = 27'd68719477;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  logic [PAD-1:0]    num_r, num_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PART_W-1:0] part;
  logic [PRD_W-1:0]  part_prd;
  logic [DIGIT-1:0]  q_dig;
  logic [PART_W-1:0] q_x1000;
  logic [PART_W-1:0] part_rem;

  // Bring the next digit down under the remainder and divide the partial
  assign part     = {rem_r, num_r[PAD-1 -: DIGIT]};
  assign part_prd = {{RCP_W{1'b0}}, part} * {{PART_W{1'b0}}, RCP};
  assign q_dig    = part_prd[RCP_SH +: DIGIT];
  // q * 1000 = q * 1024 - q * 16 - q * 8
  assign q_x1000  = {q_dig, 10'b0}
                  - {{(PART_W - DIGIT - 4){1'b0}}, q_dig, 4'b0}
                  - {{(PART_W - DIGIT - 3){1'b0}}, q_dig, 3'b0};
  assign part_rem = part - q_x1000;
  assign num_nxt  = {num_r[PAD-DIGIT-1:0], q_dig};
  assign rem_nxt  = part_rem[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= PAD'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done   = done_r;
  assign quot   = num_r[DIV_W-1:0];
  assign rem_nz = (rem_r != '0);

endmodule

`default_nettype wire

// ===== rtl/wodr_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin of a heading in Q1.15.
`timescale 1ns / 1ps
`default_nettype none

module wodr_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [wodr_pkg::ANG_W-1:0] angle,
  output logic                              done,
  output logic signed [wodr_pkg::TRIG_W-1:0] cos_q15,
  output logic signed [wodr_pkg::TRIG_W-1:0] sin_q15
);
  import wodr_pkg::*;

  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] GAIN_Q30  = 34'sh026DD3B6A;
  localparam logic signed [XY_W-1:0] ROUND_Q15 = XY_W'(1 << 14);
  localparam logic signed [XY_W-1:0] TRIG_HI   = XY_W'((1 << (TRIG_W - 1)) - 1);
  localparam logic signed [XY_W-1:0] TRIG_LO   = -TRIG_HI - XY_W'(1);
  localparam logic [ATAN_IDX_W-1:0]  IT_LAST   = ATAN_IDX_W'(ITERATIONS - 1);

  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [ANG_W-1:0]  z_r;
  logic [ATAN_IDX_W-1:0]    it_r;
  logic                     neg_r;
  logic                     busy_r;
  logic                     fin_r;
  logic                     done_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  logic signed [HSUM_W-1:0] ang_ext;
  logic signed [HSUM_W-1:0] z_init;
  logic                     neg_init;
  logic signed [XY_W-1:0]   dx, dy;
  logic signed [ANG_W-1:0]  at;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [XY_W-1:0] s;
    t = (v + ROUND_Q15) >>> 15;
    if (t > TRIG_HI) begin
      s = TRIG_HI;
    end else if (t < TRIG_LO) begin
      s = TRIG_LO;
    end else begin
      s = t;
    end
    return s[TRIG_W-1:0];
  endfunction

  // Fold headings at or above a quarter turn, or below minus a quarter turn, back by a half turn
  always_comb begin
    ang_ext = HSUM_W'(angle);
    if (ang_ext >= QUARTER_TURN) begin
      z_init   = ang_ext - HALF_TURN;
      neg_init = 1'b1;
    end else if (ang_ext < -QUARTER_TURN) begin
      z_init   = ang_ext + HALF_TURN;
      neg_init = 1'b1;
    end else begin
      z_init   = ang_ext;
      neg_init = 1'b0;
    end
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = atan_udeg(it_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + ATAN_IDX_W'(1);
        if (it_r == IT_LAST) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= GAIN_Q30;
      y_r   <= '0;
      z_r   <= z_init[ANG_W-1:0];
      neg_r <= neg_init;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (fin_r) begin
      cos_r <= to_q15(neg_r ? -x_r : x_r);
      sin_r <= to_q15(neg_r ? -y_r : y_r);
    end
  end

  assign done    = done_r;
  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for the wheel odometry block: random ticks, tracked pose, field compare.
`timescale 1ns / 1ps

module tb;
  import wodr_pkg::*;

  // Build the block at its default sizes; the pose tracker below uses the same ones.
  localparam int CORDIC_STEPS = CORDIC_ITERS_DEF;
  localparam int OFF_W        = OFFSET_W_DEF;

  localparam longint TURN_FULL    = 360000000;
  localparam longint TURN_HALF    = 180000000;
  localparam longint TURN_QUARTER = 90000000;
  localparam longint CORDIC_START = 652032874;   // 1/K in Q2.30
  localparam longint OFF_MAX      = (longint'(1) <<< (OFF_W - 1)) - 1;
  localparam longint OFF_MIN      = -OFF_MAX - 1;
  localparam longint POS_MAX      = 64'sd2147483647;
  localparam longint POS_MIN      = -64'sd2147483648;
  localparam int     FIX_MAX      = 32'sh7fff_ffff;
  localparam int     FIX_MIN      = 32'sh8000_0000;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     PHASE_TICKS  = 70;

  typedef struct {
    logic signed [SPEED_W-1:0] speed;
    logic signed [RATE_W-1:0]  turn_rate;
    logic signed [POS_W-1:0]   fix_x;
    logic signed [POS_W-1:0]   fix_y;
  } tick_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [ANG_W-1:0] heading;
  } pose_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [PERIOD_W-1:0] cfg_wr_data;

  wodr_in_if  tick_ch ();
  wodr_out_if pose_ch ();

  wheel_odometry_dead_reckoning #(
    .CORDIC_ITERATIONS (CORDIC_STEPS),
    .OFFSET_WIDTH      (OFF_W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (tick_ch),
    .out_ch      (pose_ch)
  );

  // Tracked copy of the block's state and its period register.
  logic [PERIOD_W-1:0] cfg_period;
  longint              head_udeg;
  longint              off_x_nm;
  longint              off_y_nm;

  // atan(2^-i) in microdegrees, rounded to nearest.
  longint atan_step_udeg [0:31] = '{
    45000000, 26565051, 14036243, 7125016, 3576334, 1789911, 895174, 447614,
    223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
    874, 437, 219, 109, 55, 27, 14, 7,
    3, 2, 1, 0, 0, 0, 0, 0
  };

  tick_t  tick_q [$];     // ticks waiting for the driver
  pose_t  pose_q [$];     // poses owed by the block, oldest first
  tick_t  tick_cur;
  pose_t  pose_want;
  int     in_gap;
  int     out_stall;
  bit     in_calm;
  bit     out_calm;
  bit     in_busy;
  int     errors;
  int     cycle_cnt;

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pose tracker
  // ---------------------------------------------------------------------------

  // Round a Q2.30 value to Q1.15 and clamp it.
  function automatic longint q15_round(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Rotation-mode CORDIC; fold headings at or above 90 or below -90 degrees by a half
  // turn and negate both outputs afterwards.
  function automatic void rotate_unit(input longint ang, output longint cos_q15,
                                      output longint sin_q15);
    longint x, y, z, dx, dy;
    bit     flip;
    flip = 1'b0;
    x = CORDIC_START;
    y = 0;
    if (ang >= TURN_QUARTER) begin
      ang -= TURN_HALF;
      flip = 1'b1;
    end else if (ang < -TURN_QUARTER) begin
      ang += TURN_HALF;
      flip = 1'b1;
    end
    z = ang;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step_udeg[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_step_udeg[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q15 = q15_round(x);
    sin_q15 = q15_round(y);
  endfunction

  function automatic longint clamp_offset(input longint v);
    if (v > OFF_MAX) return OFF_MAX;
    if (v < OFF_MIN) return OFF_MIN;
    return v;
  endfunction

  // Fix plus the offset in micrometres (floor), clamped to 32 bits.
  function automatic logic signed [POS_W-1:0] place_um(input logic signed [POS_W-1:0] fix,
                                                       input longint off);
    longint q, p;
    q = off / 1000;
    if (off < 0 && off % 1000 != 0) q--;
    p = longint'(fix) + q;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return p[POS_W-1:0];
  endfunction

  // Advance the tracked heading and offsets by one tick and return the pose.
  function automatic pose_t advance_pose(input tick_t t);
    longint h, travel, cs, sn;
    pose_t  r;
    h = head_udeg + (longint'(t.turn_rate) * longint'(cfg_period)) / 1000;
    h = h - (h / TURN_FULL) * TURN_FULL;
    if (h >= TURN_HALF) h -= TURN_FULL;
    else if (h < -TURN_HALF) h += TURN_FULL;
    head_udeg = h;
    travel = longint'(t.speed) * longint'(cfg_period);
    rotate_unit(h, cs, sn);
    off_x_nm = clamp_offset(off_x_nm + ((travel * cs) >>> 15));
    off_y_nm = clamp_offset(off_y_nm + ((travel * sn) >>> 15));
    r.pos_x   = place_um(t.fix_x, off_x_nm);
    r.pos_y   = place_um(t.fix_y, off_y_nm);
    r.heading = h[ANG_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long; none in a calm stretch.
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  task automatic queue_tick(input int sp, input int rt, input int fx, input int fy);
    tick_t t;
    t.speed     = SPEED_W'(sp);
    t.turn_rate = RATE_W'(rt);
    t.fix_x     = fx;
    t.fix_y     = fy;
    tick_q.push_back(t);
  endtask

  // Random tick: full-range fields mixed with extremes and slow, gentle motion.
  function automatic tick_t random_tick();
    tick_t t;
    case ($urandom_range(0, 9))
      0:       t.speed = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    t.speed = SPEED_W'(int'($urandom_range(0, 400)) - 200);
      default: t.speed = SPEED_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       t.turn_rate = $urandom_range(0, 1) ? 21'sh0f_ffff : 21'sh10_0000;
      1, 2, 3: t.turn_rate = RATE_W'(int'($urandom_range(0, 200000)) - 100000);
      4:       t.turn_rate = '0;
      default: t.turn_rate = RATE_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       t.fix_x = $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
      1:       t.fix_x = int'($urandom_range(0, 20000)) - 10000;
      default: t.fix_x = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       t.fix_y = $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
      1:       t.fix_y = int'($urandom_range(0, 20000)) - 10000;
      default: t.fix_y = $urandom;
    endcase
    return t;
  endfunction

  // Hold until every queued tick has transferred and every pose has come back.
  task automatic wait_drained();
    while (tick_q.size() != 0 || tick_ch.valid || pose_q.size() != 0) @(negedge clk);
  endtask

  // Write the period while the block sits idle, then queue a batch of random ticks.
  task automatic run_phase(input logic [PERIOD_W-1:0] period, input int count);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(posedge clk);
    cfg_period = period;
    cfg_wr_en  <= 1'b0;
    @(negedge clk);
    repeat (count) tick_q.push_back(random_tick());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued ticks, insert gaps after each transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      in_busy = tick_ch.valid;
      // On a transfer, fold the tick into the tracked pose right away.
      if (tick_ch.valid && tick_ch.ready) begin
        pose_q.push_back(advance_pose(tick_cur));
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          tick_ch.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          tick_cur = tick_q.pop_front();
          tick_ch.valid            <= 1'b1;
          tick_ch.speed_mm_s       <= tick_cur.speed;
          tick_ch.turn_rate_mdeg_s <= tick_cur.turn_rate;
          tick_ch.fix_x_um         <= tick_cur.fix_x;
          tick_ch.fix_y_um         <= tick_cur.fix_y;
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_gap = idle_len(in_calm);
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall ready at random, compare each pose against the oldest one owed.
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pose_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (pose_ch.valid && pose_ch.ready) begin
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pose x=%0d y=%0d heading=%0d", $time,
                   pose_ch.pos_x_um, pose_ch.pos_y_um, pose_ch.heading_out_udeg);
        end else begin
          pose_want = pose_q.pop_front();
          if (pose_ch.pos_x_um !== pose_want.pos_x)
            note_mismatch("pos_x_um", pose_want.pos_x, pose_ch.pos_x_um);
          if (pose_ch.pos_y_um !== pose_want.pos_y)
            note_mismatch("pos_y_um", pose_want.pos_y, pose_ch.pos_y_um);
          if (pose_ch.heading_out_udeg !== pose_want.heading)
            note_mismatch("heading_out_udeg", pose_want.heading, pose_ch.heading_out_udeg);
        end
      end
      if ($urandom_range(0, 59) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        pose_ch.ready <= 1'b0;
      end else begin
        pose_ch.ready <= 1'b1;
        out_stall = idle_len(out_calm);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed ticks at the reset period, then random phases.
  // ---------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    tick_ch.valid            = 1'b0;
    tick_ch.speed_mm_s       = '0;
    tick_ch.turn_rate_mdeg_s = '0;
    tick_ch.fix_x_um         = '0;
    tick_ch.fix_y_um         = '0;
    pose_ch.ready            = 1'b0;
    cfg_period = PERIOD_RST;
    head_udeg  = 0;
    off_x_nm   = 0;
    off_y_nm   = 0;
    errors     = 0;
    cycle_cnt  = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Standing still, then small turns at full forward and reverse speed, one the other way
    // at crawl speed, and a rate of -1 millidegree/s that leaves a ten-microdegree heading change.
    queue_tick(0, 0, 0, 0);
    queue_tick(32767, 9000, 0, 0);
    queue_tick(-32768, 9000, 100, -100);
    queue_tick(32767, 9000, -1, 1);
    queue_tick(1, -9000, 0, 0);
    queue_tick(32767, -1, 0, 0);
    // Fastest turns both ways with the fix at its extremes, then two moderate turns.
    queue_tick(-32768, 21'sh0f_ffff, FIX_MAX, FIX_MIN);
    queue_tick(32767, 21'sh10_0000, FIX_MIN, FIX_MAX);
    queue_tick(32767, 45000, 0, 0);
    queue_tick(-32768, -45000, 0, 0);
    // Offsets held: one of each pair of extreme fixes has to saturate.
    queue_tick(0, 0, FIX_MAX, FIX_MAX);
    queue_tick(0, 0, FIX_MIN, FIX_MIN);
    queue_tick(-1, 13500, FIX_MAX, FIX_MIN);
    queue_tick(1, -27000, FIX_MIN, FIX_MAX);
    queue_tick(12345, 135000, 987654, -987654);
    queue_tick(-12345, -180000, -1, -1);
    queue_tick(32767, 360000, 0, 0);
    queue_tick(-32768, -360000, 0, 0);

    // Longest period, zero period (nothing moves or turns), shortest, then a mix.
    run_phase(16'hffff, PHASE_TICKS);
    run_phase(16'd0, PHASE_TICKS);
    run_phase(16'd1, PHASE_TICKS);
    run_phase(PERIOD_W'($urandom_range(1, 65535)), PHASE_TICKS);
    run_phase(PERIOD_RST, PHASE_TICKS);
    run_phase(PERIOD_W'($urandom_range(1, 200)), PHASE_TICKS);
    run_phase(PERIOD_W'($urandom_range(1, 65535)), PHASE_TICKS);

    wait_drained();
    // Let any stray pose surface before the verdict.
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wodr_pkg.sv
rtl/wodr_if.sv
rtl/wodr_div1000.sv
rtl/wodr_cordic.sv
rtl/wheel_odometry_dead_reckoning.sv
test/tb.sv
